// File: design/lprd_pkg.sv
package lprd_pkg;

    localparam int FRAME_LIMIT = 4096;
    localparam int FRAME_W = $clog2(FRAME_LIMIT + 1);

    // result queue, room for the two results one word can cause
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [2:0] M_GET = 3'b001;
    localparam logic [2:0] M_SET = 3'b010;
    localparam logic [2:0] M_DEL = 3'b100;
    localparam logic [2:0] M_ALL = 3'b111;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] token_byte;
        logic [9:0] token_index;
        logic       token_end;
        logic [1:0] status;
        logic [1:0] command;
        logic [9:0] token_count;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // which command words have lower-case char c at position pos
    function automatic logic [2:0] match_mask(input logic [7:0] c, input logic [1:0] pos);
        logic [2:0] m;
        m = 3'b000;
        case (pos)
            2'd0:
            begin
                if (c == 8'h67) m = m | M_GET;
                if (c == 8'h73) m = m | M_SET;
                if (c == 8'h64) m = m | M_DEL;
            end
            2'd1:
            begin
                if (c == 8'h65) m = M_ALL;
            end
            2'd2:
            begin
                if (c == 8'h74) m = M_GET | M_SET;
                if (c == 8'h6C) m = M_DEL;
            end
            default:
            begin
                m = 3'b000;
            end
        endcase
        return m;
    endfunction

endpackage

// File: design/lprd_core.sv
module lprd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           data_byte,
    output lprd_pkg::push_t      push
);

    typedef enum logic [2:0] {
        PH_LEN,
        PH_COUNT,
        PH_TLEN,
        PH_TBYTES,
        PH_SKIP
    } phase_t;

    localparam int FW = lprd_pkg::FRAME_W;

    phase_t        phase_reg, phase_next;
    logic [1:0]    pos_reg, pos_next;
    logic [23:0]   shift_reg, shift_next;
    logic [FW-1:0] frame_left_reg, frame_left_next;
    logic [31:0]   tokens_left_reg, tokens_left_next;
    logic [FW-1:0] tbytes_left_reg, tbytes_left_next;
    logic [9:0]    tnum_reg, tnum_next;
    logic [1:0]    ftpos_reg, ftpos_next;
    logic [2:0]    ftmatch_reg, ftmatch_next;
    logic          halted_reg, halted_next;

    logic          done;
    logic [31:0]   v;
    logic [7:0]    c;
    logic          do_adv;
    logic          do_fail;
    logic          emit_tok;
    logic          tok_end;
    logic          emit_ver;
    logic [1:0]    ver_status;
    logic [1:0]    ver_cmd;
    lprd_pkg::result_t tok_res;
    lprd_pkg::result_t ver_res;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        shift_next = shift_reg;
        frame_left_next = frame_left_reg;
        tokens_left_next = tokens_left_reg;
        tbytes_left_next = tbytes_left_reg;
        tnum_next = tnum_reg;
        ftpos_next = ftpos_reg;
        ftmatch_next = ftmatch_reg;
        halted_next = halted_reg;
        do_adv = 1'b0;
        do_fail = 1'b0;
        emit_tok = 1'b0;
        tok_end = 1'b0;
        emit_ver = 1'b0;
        ver_status = lprd_pkg::ST_OK;
        ver_cmd = lprd_pkg::CMD_UNKNOWN;

        done = (pos_reg == 2'd3);
        v = {data_byte, shift_reg};
        c = (data_byte >= 8'h41 && data_byte <= 8'h5A) ? data_byte + 8'd32 : data_byte;

        if (take && !halted_reg)
        begin
            // little-endian field assembly, shared by every length field
            if (phase_reg != PH_TBYTES && phase_reg != PH_SKIP)
            begin
                pos_next = pos_reg + 2'd1;
                if (done)
                begin
                    shift_next = '0;
                end
                else
                begin
                    case (pos_reg)
                        2'd0: shift_next[7:0] = data_byte;
                        2'd1: shift_next[15:8] = data_byte;
                        default: shift_next[23:16] = data_byte;
                    endcase
                end
            end

            if (phase_reg == PH_LEN)
            begin
                if (done)
                begin
                    tnum_next = '0;
                    ftpos_next = '0;
                    ftmatch_next = lprd_pkg::M_ALL;
                    if (v > 32'(lprd_pkg::FRAME_LIMIT))
                    begin
                        emit_ver = 1'b1;
                        ver_status = lprd_pkg::ST_TOO_LONG;
                        halted_next = 1'b1;
                    end
                    else if (v == 32'd0)
                    begin
                        emit_ver = 1'b1;
                        ver_status = lprd_pkg::ST_MALFORMED;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        frame_left_next = v[FW-1:0];
                        phase_next = PH_COUNT;
                    end
                end
            end
            else
            begin
                if (frame_left_reg != '0)
                begin
                    frame_left_next = frame_left_reg - FW'(1);
                end
                unique case (phase_reg)
                    PH_COUNT:
                    begin
                        if (done)
                        begin
                            tokens_left_next = v;
                            do_adv = 1'b1;
                        end
                        else if (frame_left_next == '0)
                        begin
                            emit_ver = 1'b1;
                            ver_status = lprd_pkg::ST_MALFORMED;
                            halted_next = 1'b1;
                        end
                    end
                    PH_TLEN:
                    begin
                        if (done)
                        begin
                            if (v > 32'(frame_left_next))
                            begin
                                do_fail = 1'b1;
                            end
                            else if (v == 32'd0)
                            begin
                                if (tnum_reg == '0 && ftpos_reg != 2'd3)
                                begin
                                    ftmatch_next = '0;
                                end
                                tnum_next = tnum_reg + 10'd1;
                                tokens_left_next = tokens_left_reg - 32'd1;
                                do_adv = 1'b1;
                            end
                            else
                            begin
                                tbytes_left_next = v[FW-1:0];
                                phase_next = PH_TBYTES;
                            end
                        end
                        else if (frame_left_next == '0)
                        begin
                            emit_ver = 1'b1;
                            ver_status = lprd_pkg::ST_MALFORMED;
                            halted_next = 1'b1;
                        end
                    end
                    PH_TBYTES:
                    begin
                        if (tnum_reg == '0)
                        begin
                            if (ftpos_reg != 2'd3)
                            begin
                                ftmatch_next = ftmatch_reg & lprd_pkg::match_mask(c, ftpos_reg);
                                ftpos_next = ftpos_reg + 2'd1;
                            end
                            else
                            begin
                                ftmatch_next = '0;
                            end
                        end
                        if (tbytes_left_reg != '0)
                        begin
                            tbytes_left_next = tbytes_left_reg - FW'(1);
                        end
                        emit_tok = 1'b1;
                        tok_end = (tbytes_left_next == '0);
                        if (tok_end)
                        begin
                            // first token must be exactly three bytes
                            if (tnum_reg == '0 && ftpos_next != 2'd3)
                            begin
                                ftmatch_next = '0;
                            end
                            tnum_next = tnum_reg + 10'd1;
                            tokens_left_next = tokens_left_reg - 32'd1;
                            do_adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (frame_left_next == '0)
                        begin
                            emit_ver = 1'b1;
                            ver_status = lprd_pkg::ST_MALFORMED;
                            halted_next = 1'b1;
                        end
                    end
                endcase
            end

            if (do_adv)
            begin
                if (tokens_left_next == 32'd0)
                begin
                    if (frame_left_next == '0)
                    begin
                        emit_ver = 1'b1;
                        ver_status = lprd_pkg::ST_OK;
                        phase_next = PH_LEN;
                        if (tnum_next == 10'd2 && ftmatch_next[0])
                        begin
                            ver_cmd = lprd_pkg::CMD_GET;
                        end
                        else if (tnum_next == 10'd2 && ftmatch_next[2])
                        begin
                            ver_cmd = lprd_pkg::CMD_DEL;
                        end
                        else if (tnum_next == 10'd3 && ftmatch_next[1])
                        begin
                            ver_cmd = lprd_pkg::CMD_SET;
                        end
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                else if (frame_left_next == '0)
                begin
                    emit_ver = 1'b1;
                    ver_status = lprd_pkg::ST_MALFORMED;
                    halted_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_TLEN;
                end
            end

            // bad frame: swallow the rest, verdict on its last word
            if (do_fail)
            begin
                if (frame_left_next == '0)
                begin
                    emit_ver = 1'b1;
                    ver_status = lprd_pkg::ST_MALFORMED;
                    halted_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
        end
    end

    always_comb
    begin
        tok_res.item_kind = lprd_pkg::KIND_TOKEN;
        tok_res.token_byte = data_byte;
        tok_res.token_index = tnum_reg;
        tok_res.token_end = tok_end;
        tok_res.status = lprd_pkg::ST_OK;
        tok_res.command = lprd_pkg::CMD_GET;
        tok_res.token_count = '0;
        tok_res.last = !emit_ver;

        ver_res.item_kind = lprd_pkg::KIND_VERDICT;
        ver_res.token_byte = '0;
        ver_res.token_index = '0;
        ver_res.token_end = 1'b0;
        ver_res.status = ver_status;
        ver_res.command = ver_cmd;
        ver_res.token_count = tnum_next;
        ver_res.last = 1'b1;

        push.count = {1'b0, emit_tok} + {1'b0, emit_ver};
        push.first = emit_tok ? tok_res : ver_res;
        push.second = ver_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            pos_reg <= '0;
            shift_reg <= '0;
            frame_left_reg <= '0;
            tokens_left_reg <= '0;
            tbytes_left_reg <= '0;
            tnum_reg <= '0;
            ftpos_reg <= '0;
            ftmatch_reg <= lprd_pkg::M_ALL;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            shift_reg <= shift_next;
            frame_left_reg <= frame_left_next;
            tokens_left_reg <= tokens_left_next;
            tbytes_left_reg <= tbytes_left_next;
            tnum_reg <= tnum_next;
            ftpos_reg <= ftpos_next;
            ftmatch_reg <= ftmatch_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// File: design/lprd_queue.sv
module lprd_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lprd_pkg::push_t             push,
    input  logic                        pop,
    output lprd_pkg::result_t           head,
    output logic [lprd_pkg::QAW:0]      fill
);

    localparam int AW = lprd_pkg::QAW;

    lprd_pkg::result_t slot_reg [lprd_pkg::QDEPTH];
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW:0]   fill_reg, fill_next;
    logic [AW-1:0] wr_second;

    assign wr_second = wr_reg + AW'(1);

    always_comb
    begin
        wr_next = wr_reg + AW'(push.count);
        rd_next = pop ? rd_reg + AW'(1) : rd_reg;
        fill_next = fill_reg + (AW + 1)'(push.count) - (AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            fill_reg <= fill_next;
        end
    end

    assign head = slot_reg[rd_reg];
    assign fill = fill_reg;

endmodule

// File: design/length_prefixed_request_deframer.sv
// latency: results of an accepted word are offered in the next cycle when the queue
// is empty, later behind results already waiting
// throughput: one word per cycle; a word giving both a token byte and a verdict
// yields two results, popped one at a time; input stalls while more than two results wait
// four-entry result queue between the parse logic and the output port
// reset: asynchronous, active low; back to waiting for a frame length, queue empty
module length_prefixed_request_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       item_kind,
    output logic [7:0] token_byte,
    output logic [9:0] token_index,
    output logic       token_end,
    output logic [1:0] status,
    output logic [1:0] command,
    output logic [9:0] token_count,
    output logic       last
);

    lprd_pkg::push_t           push;
    lprd_pkg::result_t         head;
    logic [lprd_pkg::QAW:0]    fill;
    logic                      take;
    logic                      pop;

    // keep room for two results so the results of every taken word fit
    assign byte_stall = (fill > (lprd_pkg::QAW + 1)'(lprd_pkg::QDEPTH - 2));
    assign take = byte_valid && !byte_stall;
    assign result_valid = (fill != '0);
    assign pop = result_valid && !result_stall;

    lprd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .push      (push)
    );

    lprd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .fill  (fill)
    );

    assign item_kind = head.item_kind;
    assign token_byte = head.token_byte;
    assign token_index = head.token_index;
    assign token_end = head.token_end;
    assign status = head.status;
    assign command = head.command;
    assign token_count = head.token_count;
    assign last = head.last;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= (lprd_pkg::QAW + 1)'(lprd_pkg::QDEPTH))
        else $error("result queue overflow");

    a_no_push_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> push.count == 2'd0)
        else $error("results pushed without an accepted word");

    a_too_long_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && item_kind == lprd_pkg::KIND_VERDICT
            && status == lprd_pkg::ST_TOO_LONG)
        |-> (token_count == 10'd0 && command == lprd_pkg::CMD_UNKNOWN && last))
        else $error("bad too-long verdict");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> (item_kind == lprd_pkg::KIND_TOKEN && token_end))
        else $error("non-final result must be a token's last byte");

endmodule
